/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the restriction block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that ante implies cons in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that ante implies cons in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/gfwr_pkg.sv */
// Shared types and constants of the full-weighting restriction block.
// No dependencies; imported by every module of the block.
package gfwr_pkg;

   // Storage and sample sizing
   localparam int MAX_FINE_POINTS = 1025;
   localparam int SAMPLE_BITS     = 24;
   localparam int IDX_W           = $clog2(MAX_FINE_POINTS);

   // Field widths
   localparam int FINE_W   = 11;
   localparam int COARSE_W = 10;
   localparam int INNER_W  = 9;
   localparam int GAIN_W   = 16;
   localparam int BORDER_W = 4;

   // Arithmetic widths: nine taps with weights summing to 16
   localparam int SUM_W      = SAMPLE_BITS + 4;
   localparam int PROD_W     = SUM_W + GAIN_W + 1;
   localparam int FRAC_SHIFT = 18;

   // Result packing
   localparam int RSP_BITS   = SAMPLE_BITS + 2 * COARSE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FINE_WIDTH    = 3'd0,
      CSR_FINE_HEIGHT   = 3'd1,
      CSR_BORDER_INJECT = 3'd2,
      CSR_GAIN          = 3'd3,
      CSR_INNER_FIRST_X = 3'd4,
      CSR_INNER_LAST_X  = 3'd5,
      CSR_INNER_FIRST_Y = 3'd6,
      CSR_INNER_LAST_Y  = 3'd7
   } csr_index_type;

   // Border enable bit positions
   localparam int BORDER_X_LOW  = 0;
   localparam int BORDER_X_HIGH = 1;
   localparam int BORDER_Y_LOW  = 2;
   localparam int BORDER_Y_HIGH = 3;

   typedef struct packed {
      logic [FINE_W-1:0]   fine_width;
      logic [FINE_W-1:0]   fine_height;
      logic [BORDER_W-1:0] border_inject;
      logic [GAIN_W-1:0]   gain;
      logic [INNER_W-1:0]  inner_first_x;
      logic [INNER_W-1:0]  inner_last_x;
      logic [INNER_W-1:0]  inner_first_y;
      logic [INNER_W-1:0]  inner_last_y;
   } cfg_type;

   // Line buffer write command
   typedef struct packed {
      logic                   en;
      logic [IDX_W-1:0]       addr;
      logic [SAMPLE_BITS-1:0] older;
      logic [SAMPLE_BITS-1:0] newer;
   } line_wr_type;

   // Result description carried down the arithmetic pipeline
   typedef struct packed {
      logic                   size_error;
      logic                   last_point;
      logic [COARSE_W-1:0]    cx;
      logic [COARSE_W-1:0]    cy;
      logic                   weighted;
      logic [SAMPLE_BITS-1:0] direct;
   } res_meta_type;

endpackage

/* hw/rtl/gfwr_line_buf.sv */
// Two fine-row line memories with one read and one write port each.
// Depends on gfwr_pkg; clears both memories after reset.
module gfwr_line_buf (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [gfwr_pkg::IDX_W-1:0]       rd_addr,
   input  gfwr_pkg::line_wr_type            wr,
   output logic [gfwr_pkg::SAMPLE_BITS-1:0] rd_older,
   output logic [gfwr_pkg::SAMPLE_BITS-1:0] rd_newer,
   output logic                             busy
);
   import gfwr_pkg::*;

   logic [SAMPLE_BITS-1:0] older_mem [MAX_FINE_POINTS];
   logic [SAMPLE_BITS-1:0] newer_mem [MAX_FINE_POINTS];

   logic [SAMPLE_BITS-1:0] rd_older_ff;
   logic [SAMPLE_BITS-1:0] rd_newer_ff;
   logic                   busy_ff, busy_in;
   logic [IDX_W-1:0]       clr_ff, clr_in;

   // Sweep one entry a cycle until the last entry is cleared
   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == IDX_W'(MAX_FINE_POINTS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   // Write port: clearing pass or row update
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         older_mem[clr_ff] <= '0;
         newer_mem[clr_ff] <= '0;
      end else if (wr.en) begin
         older_mem[wr.addr] <= wr.older;
         newer_mem[wr.addr] <= wr.newer;
      end
   end

   // Read port, registered; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older_ff <= older_mem[rd_addr];
         rd_newer_ff <= newer_mem[rd_addr];
      end
   end

   assign rd_older = rd_older_ff;
   assign rd_newer = rd_newer_ff;
   assign busy     = busy_ff;

endmodule

/* hw/rtl/gfwr_window.sv */
// 3x3 window stage: merges line reads with shift registers, writes rows back,
// forms the stencil sum and decides what each coarse point gets. Uses gfwr_pkg.
module gfwr_window (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             adv,
   input  logic                             load,
   input  logic [gfwr_pkg::SAMPLE_BITS-1:0] sample,
   input  logic [gfwr_pkg::FINE_W-1:0]      x,
   input  logic [gfwr_pkg::FINE_W-1:0]      y,
   input  logic                             x_inr,
   input  gfwr_pkg::cfg_type                cfg,
   input  logic [gfwr_pkg::SAMPLE_BITS-1:0] rd_older,
   input  logic [gfwr_pkg::SAMPLE_BITS-1:0] rd_newer,
   output gfwr_pkg::line_wr_type            wr,
   output logic                             res_valid,
   output gfwr_pkg::res_meta_type           res_meta,
   output logic [gfwr_pkg::SUM_W-1:0]       res_sum
);
   import gfwr_pkg::*;

   // Stage one: sample held while its line reads return
   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [FINE_W-1:0]      s1_x_ff, s1_y_ff;
   logic                   s1_inr_ff, s1_fwd_ff;
   logic                   fwd_in;

   // Window columns x-2 and x-1 of the three rows
   logic signed [SAMPLE_BITS-1:0] win_old_ff [2];
   logic signed [SAMPLE_BITS-1:0] win_new_ff [2];
   logic signed [SAMPLE_BITS-1:0] prev_ff    [2];

   logic signed [SAMPLE_BITS-1:0] o_val, n_val, s_val;
   logic signed [SUM_W-1:0]       sum;

   logic                   s2_valid_ff;
   res_meta_type           s2_meta_ff, meta;
   logic [SUM_W-1:0]       s2_sum_ff;
   logic                   emit;

   logic [FINE_W-1:0]      xm1, ym1;
   logic [COARSE_W-1:0]    hx, hy, cx, cy;
   logic                   xe, ye, xhit, yhit, odd, interior, inject;
   logic signed [SAMPLE_BITS-1:0] sel;

   // Forward the row written back on the same edge as a read of that column
   assign fwd_in = s1_valid_ff && s1_inr_ff && x_inr && (s1_x_ff == x);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_sample_ff <= sample;
         s1_x_ff      <= x;
         s1_y_ff      <= y;
         s1_inr_ff    <= x_inr;
         s1_fwd_ff    <= fwd_in;
      end
   end

   // Select line values: forwarded, stored, or zero beyond the buffer
   always_comb begin
      s_val = $signed(s1_sample_ff);
      if (s1_fwd_ff) begin
         o_val = win_new_ff[1];
         n_val = prev_ff[1];
      end else if (s1_inr_ff) begin
         o_val = $signed(rd_older);
         n_val = $signed(rd_newer);
      end else begin
         o_val = '0;
         n_val = '0;
      end
   end

   // Write the shifted rows back at this column
   always_comb begin
      wr.en    = s1_valid_ff && adv && s1_inr_ff;
      wr.addr  = IDX_W'(s1_x_ff);
      wr.older = n_val;
      wr.newer = s1_sample_ff;
   end

   // Shift the window on every item
   always_ff @(posedge clock) begin
      if (reset) begin
         win_old_ff[0] <= '0;
         win_old_ff[1] <= '0;
         win_new_ff[0] <= '0;
         win_new_ff[1] <= '0;
         prev_ff[0]    <= '0;
         prev_ff[1]    <= '0;
      end else if (s1_valid_ff && adv) begin
         win_old_ff[0] <= win_old_ff[1];
         win_old_ff[1] <= o_val;
         win_new_ff[0] <= win_new_ff[1];
         win_new_ff[1] <= n_val;
         prev_ff[0]    <= prev_ff[1];
         prev_ff[1]    <= s_val;
      end
   end

   // 1-2-1 by 1-2-1 stencil sum around the center tap
   assign sum = (SUM_W'(win_new_ff[1]) <<< 2)
              + ((SUM_W'(win_new_ff[0]) + SUM_W'(n_val)
                + SUM_W'(win_old_ff[1]) + SUM_W'(prev_ff[1])) <<< 1)
              + SUM_W'(win_old_ff[0]) + SUM_W'(o_val)
              + SUM_W'(prev_ff[0]) + SUM_W'(s_val);

   // Coarse position and point class
   always_comb begin
      odd  = cfg.fine_width[0] || cfg.fine_height[0];
      hx   = cfg.fine_width[FINE_W-1:1];
      hy   = cfg.fine_height[FINE_W-1:1];
      xe   = (s1_x_ff == cfg.fine_width);
      ye   = (s1_y_ff == cfg.fine_height);
      xhit = xe || (s1_x_ff[0] && (s1_x_ff < cfg.fine_width));
      yhit = ye || (s1_y_ff[0] && (s1_y_ff < cfg.fine_height));
      xm1  = s1_x_ff - 1'b1;
      ym1  = s1_y_ff - 1'b1;
      cx   = xe ? hx : xm1[FINE_W-1:1];
      cy   = ye ? hy : ym1[FINE_W-1:1];

      interior = (cx != '0) && (cx < hx)
              && (cx >= COARSE_W'(cfg.inner_first_x)) && (cx <= COARSE_W'(cfg.inner_last_x))
              && (cy != '0) && (cy < hy)
              && (cy >= COARSE_W'(cfg.inner_first_y)) && (cy <= COARSE_W'(cfg.inner_last_y));

      inject = (cfg.border_inject[BORDER_X_LOW]  && (cx == '0))
            || (cfg.border_inject[BORDER_X_HIGH] && (cx == hx))
            || (cfg.border_inject[BORDER_Y_LOW]  && (cy == '0))
            || (cfg.border_inject[BORDER_Y_HIGH] && (cy == hy));

      unique case ({ye, xe})
         2'b00: sel = win_new_ff[1];
         2'b01: sel = n_val;
         2'b10: sel = prev_ff[1];
         2'b11: sel = s_val;
      endcase
   end

   // Build the result description; an odd size reports once at the origin
   always_comb begin
      meta = '0;
      if (odd) begin
         emit            = (s1_x_ff == '0) && (s1_y_ff == '0);
         meta.size_error = 1'b1;
      end else begin
         emit            = xhit && yhit;
         meta.cx         = cx;
         meta.cy         = cy;
         meta.last_point = (cx == hx) && (cy == hy);
         meta.weighted   = interior;
         meta.direct     = (!interior && inject) ? sel : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff <= meta;
         s2_sum_ff  <= sum;
      end
   end

   assign res_valid = s2_valid_ff;
   assign res_meta  = s2_meta_ff;
   assign res_sum   = s2_sum_ff;

endmodule

/* hw/rtl/gfwr_weigh.sv */
// Gain multiply, rounding and saturation, and the result output register.
// Depends on gfwr_pkg; fed by the window stage.
module gfwr_weigh (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [gfwr_pkg::GAIN_W-1:0]     gain,
   input  logic                            in_valid,
   input  gfwr_pkg::res_meta_type          in_meta,
   input  logic [gfwr_pkg::SUM_W-1:0]      in_sum,
   output logic                            rsp_tvalid,
   output logic [gfwr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);
   import gfwr_pkg::*;

   localparam logic signed [PROD_W-1:0] SAT_MAX =
      {{(PROD_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [PROD_W-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_SHIFT - 1);

   logic                     s3_valid_ff;
   res_meta_type             s3_meta_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] rnd, quot;
   logic [SAMPLE_BITS-1:0]   sat, value;

   logic                     out_valid_ff;
   logic [RSP_DATA_W-1:0]    out_data_ff;
   logic                     out_last_ff, out_err_ff;

   // Multiply the stencil sum by the unsigned gain
   assign prod_in = PROD_W'($signed(in_sum)) * PROD_W'($signed({1'b0, gain}));

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_meta_ff <= in_meta;
         prod_ff    <= prod_in;
      end
   end

   // Round half up, drop the fraction, clamp to the sample range
   always_comb begin
      rnd  = prod_ff + ROUND_HALF;
      quot = rnd >>> FRAC_SHIFT;
      if (quot > SAT_MAX) begin
         sat = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (quot < SAT_MIN) begin
         sat = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sat = quot[SAMPLE_BITS-1:0];
      end
      value = s3_meta_ff.weighted ? sat : s3_meta_ff.direct;
   end

   // Output register; holds while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= RSP_DATA_W'({s3_meta_ff.cy, s3_meta_ff.cx, value});
         out_last_ff <= s3_meta_ff.last_point;
         out_err_ff  <= s3_meta_ff.size_error;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

endmodule

/* hw/rtl/grid_full_weighting_restriction.sv */
// Top level of the 2-D full-weighting restriction block.
// Depends on gfwr_pkg, gfwr_line_buf, gfwr_window, gfwr_weigh and assert_macros.svh.
//
// Fine samples enter in raster order (x inner) at one item per clock, and each
// coarse point passes the s1, s2, s3 and output registers after the fine
// sample that completes it. The rate is set by the line memories, which take
// one read and one write per cycle; a write-back to the column being read on
// the same edge is forwarded from the window registers. After reset the line
// memories are cleared in a pass over all 1025 entries, during which
// req_tready is low; configuration writes are taken at any time. A stall on
// rsp_tready holds the whole pipeline. An odd configured size gives one item
// with tuser set at the grid origin and no coarse points for that grid.

`include "assert_macros.svh"

module grid_full_weighting_restriction (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: sample[23:0]
   input  logic [gfwr_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: coarse_value[23:0], coarse_x[33:24], coarse_y[43:34], zero fill
   output logic [gfwr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // rsp_tuser: size_error[0]
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [gfwr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [gfwr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import gfwr_pkg::*;

   localparam cfg_type CFG_RESET = '{
      fine_width:    FINE_W'(64),
      fine_height:   FINE_W'(64),
      border_inject: BORDER_W'(0),
      gain:          GAIN_W'(16384),
      inner_first_x: INNER_W'(1),
      inner_last_x:  INNER_W'(31),
      inner_first_y: INNER_W'(1),
      inner_last_y:  INNER_W'(31)
   };

   cfg_type           cfg_ff, cfg_in;
   logic [FINE_W-1:0] col_ff, col_in, row_ff, row_in;
   logic              accept, adv, x_inr, clr_busy;

   logic [SAMPLE_BITS-1:0] rd_older, rd_newer;
   line_wr_type            wr;
   logic                   res_valid;
   res_meta_type           res_meta;
   logic [SUM_W-1:0]       res_sum;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FINE_WIDTH:    cfg_in.fine_width    = csr_wdata[FINE_W-1:0];
            CSR_FINE_HEIGHT:   cfg_in.fine_height   = csr_wdata[FINE_W-1:0];
            CSR_BORDER_INJECT: cfg_in.border_inject = csr_wdata[BORDER_W-1:0];
            CSR_GAIN:          cfg_in.gain          = csr_wdata[GAIN_W-1:0];
            CSR_INNER_FIRST_X: cfg_in.inner_first_x = csr_wdata[INNER_W-1:0];
            CSR_INNER_LAST_X:  cfg_in.inner_last_x  = csr_wdata[INNER_W-1:0];
            CSR_INNER_FIRST_Y: cfg_in.inner_first_y = csr_wdata[INNER_W-1:0];
            CSR_INNER_LAST_Y:  cfg_in.inner_last_y  = csr_wdata[INNER_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: the pipeline moves unless a result is stalled
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = !clr_busy && adv;
   assign accept     = req_tvalid && req_tready;
   assign x_inr      = int'(col_ff) < MAX_FINE_POINTS;

   // Advance the fine position; a count at or past the size wraps
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff >= cfg_ff.fine_width) begin
            col_in = '0;
            row_in = (row_ff >= cfg_ff.fine_height) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   gfwr_line_buf u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept && x_inr),
      .rd_addr  (IDX_W'(col_ff)),
      .wr       (wr),
      .rd_older (rd_older),
      .rd_newer (rd_newer),
      .busy     (clr_busy)
   );

   gfwr_window u_window (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .load      (accept),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .x         (col_ff),
      .y         (row_ff),
      .x_inr     (x_inr),
      .cfg       (cfg_ff),
      .rd_older  (rd_older),
      .rd_newer  (rd_newer),
      .wr        (wr),
      .res_valid (res_valid),
      .res_meta  (res_meta),
      .res_sum   (res_sum)
   );

   gfwr_weigh u_weigh (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .gain       (cfg_ff.gain),
      .in_valid   (res_valid),
      .in_meta    (res_meta),
      .in_sum     (res_sum),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Checks
   `ASSERT_IMPLY(a_no_row_write_in_clear, clock, reset, wr.en, !clr_busy)
   `ASSERT_NEXT(a_clear_never_restarts, clock, reset, accept, !clr_busy)
   `ASSERT_IMPLY(a_error_item_empty, clock, reset, rsp_tvalid && rsp_tuser, (rsp_tdata == '0) && !rsp_tlast)

endmodule
